>>> rtl/core/b32kd_pkg.sv
// -----------------------------------------------------------------------------
// b32kd_pkg: shared types and constants of the base32 key decoder
// Symbol table, group layout and the structs passed between the decode step
// and the top level.
// -----------------------------------------------------------------------------
package b32kd_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SymW     = 5;
  localparam int unsigned GroupLen = 8;
  localparam int unsigned GroupW   = SymW * GroupLen;
  localparam int unsigned PosW     = $clog2(GroupLen);
  localparam int unsigned MaxBytes = GroupW / 8;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned PadW     = 4;

  localparam logic [CharW-1:0] PadChar = 8'h3D;  // '='

  // Group positions at which a pad cuts the group short
  localparam logic [PosW-1:0] PosCut1 = 3'd2;
  localparam logic [PosW-1:0] PosCut2 = 3'd4;
  localparam logic [PosW-1:0] PosCut3 = 3'd5;
  localparam logic [PosW-1:0] PosLast = 3'd7;

  localparam logic [CntW-1:0] CntNone = 3'd0;
  localparam logic [CntW-1:0] CntOne  = 3'd1;
  localparam logic [CntW-1:0] CntTwo  = 3'd2;
  localparam logic [CntW-1:0] CntThree = 3'd3;
  localparam logic [CntW-1:0] CntFour = 3'd4;
  localparam logic [CntW-1:0] CntFull = 3'd5;

  typedef struct packed {
    logic [GroupW-1:0] symbols;
    logic [PosW-1:0]   position;
    logic [PadW-1:0]   pad_marks;
    logic              group_bad;
    logic              stopped;
  } dec_state_t;

  typedef struct packed {
    logic [CntW-1:0]   count;     // beats to emit, 0 when the item yields none
    logic [GroupW-1:0] bytes;     // most significant byte goes out first
    logic              byte_valid;
    logic              bad;
    logic              key_end;
  } burst_t;

  // Lenient base32 table: {unknown flag, symbol}
  function automatic logic [SymW:0] symbol_of(logic [CharW-1:0] c);
    logic [SymW:0] res;
    res = {1'b0, 5'd0};
    case (c) inside
      [8'h41:8'h5A]: res = {1'b0, SymW'(c - 8'h41)};
      [8'h61:8'h7A]: res = {1'b0, SymW'(c - 8'h61)};
      [8'h32:8'h37]: res = {1'b0, SymW'(c - 8'h32 + 8'd26)};
      8'h30:         res = {1'b0, 5'd14};
      8'h31:         res = {1'b0, 5'd11};
      8'h38:         res = {1'b0, 5'd1};
      PadChar:       res = {1'b0, 5'd0};
      default:       res = {1'b1, 5'd31};
    endcase
    return res;
  endfunction

endpackage

>>> rtl/core/b32kd_in_if.sv
// -----------------------------------------------------------------------------
// b32kd_in_if: character channel of the base32 key decoder
// One encoded character per beat, with a flag on the last one of a key.
// -----------------------------------------------------------------------------
interface b32kd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_char;
  logic       final_char;

  modport source (output valid, output key_char, output final_char, input ready);
  modport sink   (input valid, input key_char, input final_char, output ready);
endinterface

>>> rtl/core/b32kd_out_if.sv
// -----------------------------------------------------------------------------
// b32kd_out_if: byte channel of the base32 key decoder
// One decoded byte or bare end marker per beat.
// -----------------------------------------------------------------------------
interface b32kd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       byte_valid;
  logic       run_end;
  logic       key_end;
  logic       bad_symbol;

  modport source (output valid, output key_byte, output byte_valid, output run_end,
                  output key_end, output bad_symbol, input ready);
  modport sink   (input valid, input key_byte, input byte_valid, input run_end,
                  input key_end, input bad_symbol, output ready);
endinterface

>>> rtl/core/base32_key_decoder_top.sv
// -----------------------------------------------------------------------------
// base32_key_decoder_top: streaming base32 key decoder
// Character register, single-pass group decode, and a byte burst register.
// -----------------------------------------------------------------------------
// A character is taken into an input register and decoded in the next cycle;
// once it moves on, its bytes are loaded into the burst register and go out
// one per beat, most significant first. Characters that complete no group and
// end no key move on every cycle even while a burst drains. The character that
// completes a group or ends the key waits in the input register until the
// previous burst (at most five beats) is empty or its last beat is taken.
// With an open sink a group never waits, but a key end that follows right
// behind a full group holds the input until that burst reaches its last beat;
// a stalled sink stretches that wait. No clearing pass after reset.
module base32_key_decoder_top
  import b32kd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  b32kd_in_if.sink    in_i,
  b32kd_out_if.source out_o
);

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_final_q;

  dec_state_t       state_q, state_d;
  burst_t           burst;

  logic [CntW-1:0]   out_cnt_q;
  logic [GroupW-1:0] out_bytes_q;
  logic              out_bval_q;
  logic              out_bad_q;
  logic              out_kend_q;

  logic out_take;
  logic burst_free;
  logic produce;
  logic advance;

  b32kd_step u_step (
    .state_i      (state_q),
    .key_char_i   (in_char_q),
    .final_char_i (in_final_q),
    .state_o      (state_d),
    .burst_o      (burst)
  );

  assign produce    = (burst.count != CntNone);
  assign out_take   = out_o.valid && out_o.ready;
  assign burst_free = (out_cnt_q == CntNone) || ((out_cnt_q == CntOne) && out_take);
  assign advance    = in_valid_q && (!produce || burst_free);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q  <= in_i.key_char;
      in_final_q <= in_i.final_char;
    end
  end

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // burst register: load a new burst, else shift out one beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= CntNone;
    end else if (advance && produce) begin
      out_cnt_q <= burst.count;
    end else if (out_take) begin
      out_cnt_q <= out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_bytes_q <= burst.bytes;
      out_bval_q  <= burst.byte_valid;
      out_bad_q   <= burst.bad;
      out_kend_q  <= burst.key_end;
    end else if (out_take) begin
      out_bytes_q <= {out_bytes_q[GroupW-9:0], 8'h00};
    end
  end

  assign out_o.valid      = (out_cnt_q != CntNone);
  assign out_o.key_byte   = out_bytes_q[GroupW-1 -: 8];
  assign out_o.byte_valid = out_bval_q;
  assign out_o.bad_symbol = out_bad_q;
  assign out_o.run_end    = (out_cnt_q == CntOne);
  assign out_o.key_end    = out_kend_q && (out_cnt_q == CntOne);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= CntFull)
    else $error("burst count above five");

  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.byte_valid) |->
      (out_o.key_end && out_o.key_byte == 8'h00 && !out_o.bad_symbol))
    else $error("bare marker must close the key with zero payload");

  a_key_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_final_q) |=> (state_q == '0 && out_kend_q && out_o.valid))
    else $error("final character must clear state and load a key end");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_take) |=> (out_cnt_q == $past(out_cnt_q)))
    else $error("burst advanced without a taken beat");

endmodule

>>> rtl/core/b32kd_step.sv
// -----------------------------------------------------------------------------
// b32kd_step: one character through the group decoder
// Maps the character, folds it into the group and builds the byte burst.
// -----------------------------------------------------------------------------
module b32kd_step
  import b32kd_pkg::*;
(
  input  dec_state_t       state_i,
  input  logic [CharW-1:0] key_char_i,
  input  logic             final_char_i,
  output dec_state_t       state_o,
  output burst_t           burst_o
);

  logic [SymW:0]   sym_lookup;
  logic [SymW-1:0] sym;
  logic            sym_bad;
  logic            is_pad;
  dec_state_t      grp;
  logic [CntW-1:0] cnt;

  assign sym_lookup = symbol_of(key_char_i);
  assign sym        = sym_lookup[SymW-1:0];
  assign sym_bad    = sym_lookup[SymW];
  assign is_pad     = (key_char_i == PadChar);

  always_comb begin
    grp = state_i;
    cnt = CntNone;
    burst_o = '0;

    if (!state_i.stopped) begin
      grp.symbols   = {state_i.symbols[GroupW-SymW-1:0], sym};
      grp.group_bad = state_i.group_bad | sym_bad;
      if (is_pad) begin
        case (state_i.position)
          PosCut1: grp.pad_marks[0] = 1'b1;
          PosCut2: grp.pad_marks[1] = 1'b1;
          PosCut3: grp.pad_marks[2] = 1'b1;
          PosLast: grp.pad_marks[3] = 1'b1;
          default: ;
        endcase
      end

      if (state_i.position == PosLast) begin
        if (grp.pad_marks[0])      cnt = CntOne;
        else if (grp.pad_marks[1]) cnt = CntTwo;
        else if (grp.pad_marks[2]) cnt = CntThree;
        else if (grp.pad_marks[3]) cnt = CntFour;
        else                       cnt = CntFull;
        burst_o.count      = cnt;
        burst_o.bytes      = grp.symbols;
        burst_o.byte_valid = 1'b1;
        burst_o.bad        = grp.group_bad;
        grp.symbols   = '0;
        grp.position  = '0;
        grp.pad_marks = '0;
        grp.group_bad = 1'b0;
        grp.stopped   = (cnt != CntFull);
      end else begin
        grp.position = state_i.position + 1'b1;
      end
    end

    state_o = grp;

    if (final_char_i) begin
      // no bytes from this character: close the key with a bare marker
      if (cnt == CntNone) begin
        burst_o.count      = CntOne;
        burst_o.bytes      = '0;
        burst_o.byte_valid = 1'b0;
        burst_o.bad        = 1'b0;
      end
      burst_o.key_end = 1'b1;
      state_o = '0;
    end
  end

endmodule

>>> sim/base32_key_decoder_top_test.sv
// -----------------------------------------------------------------------------
// base32_key_decoder_top_test: self-checking bench of the base32 key decoder
// Drives encoded key characters through the character channel, predicts each
// decoded byte and end marker, and checks the byte channel against it under
// several idle and stall patterns.
// -----------------------------------------------------------------------------
module base32_key_decoder_top_test;
  import b32kd_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseItems   = 92;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned NumPhases    = 4;

  typedef struct packed {
    logic [7:0] key_char;
    logic       final_char;
  } char_beat_t;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       run_end;
    logic       key_end;
    logic       bad_symbol;
  } byte_beat_t;

  logic clk_i;
  logic rst_ni;

  b32kd_in_if  char_if ();
  b32kd_out_if byte_if ();

  base32_key_decoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (byte_if)
  );

  char_beat_t  pending_chars[$];
  byte_beat_t  expected_bytes[$];
  int unsigned chars_queued;
  int unsigned chars_taken;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // Decoder state as predicted
  logic [GroupW-1:0] grp_bits;
  logic [PosW-1:0]   grp_pos;
  logic [PadW-1:0]   pad_seen;
  logic              grp_bad;
  logic              key_stopped;

  // {unknown flag, symbol} of one character
  function automatic logic [SymW:0] char_symbol(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return {1'b0, SymW'(ch - "A")};
    if (ch >= "a" && ch <= "z") return {1'b0, SymW'(ch - "a")};
    if (ch >= "2" && ch <= "7") return {1'b0, SymW'(ch - "2" + 8'd26)};
    if (ch == "0") return {1'b0, 5'd14};
    if (ch == "1") return {1'b0, 5'd11};
    if (ch == "8") return {1'b0, 5'd1};
    if (ch == PadChar) return {1'b0, 5'd0};
    return {1'b1, 5'd31};
  endfunction

  task automatic clear_key_state();
    grp_bits    = '0;
    grp_pos     = '0;
    pad_seen    = '0;
    grp_bad     = 1'b0;
    key_stopped = 1'b0;
  endtask

  task automatic predict_key_bytes(input logic [7:0] ch, input logic fin);
    byte_beat_t    burst[MaxBytes];
    int            n_out;
    int            n_bytes;
    logic [SymW:0] sym;
    n_out = 0;
    if (!key_stopped) begin
      sym      = char_symbol(ch);
      grp_bits = {grp_bits[GroupW-SymW-1:0], sym[SymW-1:0]};
      if (sym[SymW]) grp_bad = 1'b1;
      if (ch == PadChar) begin
        case (grp_pos)
          PosCut1: pad_seen[0] = 1'b1;
          PosCut2: pad_seen[1] = 1'b1;
          PosCut3: pad_seen[2] = 1'b1;
          PosLast: pad_seen[3] = 1'b1;
          default: ;
        endcase
      end
      if (grp_pos == PosLast) begin
        // first cut position in group order wins
        if (pad_seen[0])      n_bytes = 1;
        else if (pad_seen[1]) n_bytes = 2;
        else if (pad_seen[2]) n_bytes = 3;
        else if (pad_seen[3]) n_bytes = 4;
        else                  n_bytes = MaxBytes;
        for (int j = 0; j < n_bytes; j++) begin
          burst[j] = '{key_byte: grp_bits[GroupW-1-8*j -: 8], byte_valid: 1'b1,
                       run_end: 1'b0, key_end: 1'b0, bad_symbol: grp_bad};
        end
        n_out = n_bytes;
        grp_bits = '0;
        grp_pos  = '0;
        pad_seen = '0;
        grp_bad  = 1'b0;
        if (n_bytes < MaxBytes) key_stopped = 1'b1;
      end else begin
        grp_pos = grp_pos + 1'b1;
      end
    end
    if (fin) begin
      if (n_out == 0) begin
        burst[0] = '{key_byte: 8'h00, byte_valid: 1'b0, run_end: 1'b0, key_end: 1'b0,
                     bad_symbol: 1'b0};
        n_out = 1;
      end
      burst[n_out-1].key_end = 1'b1;
      clear_key_state();
    end
    if (n_out > 0) burst[n_out-1].run_end = 1'b1;
    for (int j = 0; j < n_out; j++) expected_bytes.push_back(burst[j]);
  endtask

  task automatic queue_char(input logic [7:0] ch, input logic fin);
    pending_chars.push_back('{key_char: ch, final_char: fin});
    chars_queued++;
  endtask

  task automatic queue_text(input string s, input logic fin_on_last);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], fin_on_last && (i == s.len() - 1));
  endtask

  // Mostly alphabet characters, now and then any byte at all
  function automatic logic [7:0] pick_key_char();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    case (sel)
      0:       return 8'($urandom_range(0, 255));
      1:       return ($urandom_range(0, 2) == 0) ? "0" : (($urandom_range(0, 1) == 0) ? "1" : "8");
      2, 3, 4, 5: return 8'("a" + $urandom_range(0, 25));
      6, 7, 8: return 8'("2" + $urandom_range(0, 5));
      default: return 8'("A" + $urandom_range(0, 25));
    endcase
  endfunction

  task automatic queue_random_key();
    logic [7:0]      key_chars[$];
    int unsigned     kind;
    int unsigned     n_full;
    int unsigned     extra;
    int unsigned     broken_pos;
    logic [PosW-1:0] cut;
    kind   = $urandom_range(0, 9);
    n_full = (kind < 4) ? $urandom_range(1, 3) : $urandom_range(0, 2);
    if (kind == 9) begin
      // noise with pads sprinkled in
      extra = $urandom_range(1, 12);
      for (int i = 0; i < extra; i++) begin
        key_chars.push_back(($urandom_range(0, 3) == 0) ? PadChar : 8'($urandom_range(0, 255)));
      end
    end else begin
      for (int g = 0; g < n_full; g++) begin
        for (int p = 0; p < GroupLen; p++) key_chars.push_back(pick_key_char());
      end
      if (kind >= 4 && kind <= 6) begin
        case ($urandom_range(0, 3))
          0:       cut = PosCut1;
          1:       cut = PosCut2;
          2:       cut = PosCut3;
          default: cut = PosLast;
        endcase
        broken_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(cut, GroupLen - 1) : GroupLen;
        for (int p = 0; p < GroupLen; p++) begin
          if (p < cut) key_chars.push_back(pick_key_char());
          else if (p == broken_pos) key_chars.push_back(8'($urandom_range(0, 255)));
          else key_chars.push_back(PadChar);
        end
        // trailing characters after the cut are dropped by the block
        extra = $urandom_range(0, 3);
        for (int i = 0; i < extra; i++) key_chars.push_back(pick_key_char());
      end else if (kind >= 7) begin
        extra = $urandom_range(1, GroupLen - 1);
        for (int i = 0; i < extra; i++) key_chars.push_back(pick_key_char());
      end
    end
    foreach (key_chars[i]) queue_char(key_chars[i], i == key_chars.size() - 1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    char_if.valid      = 1'b0;
    char_if.key_char   = 8'h00;
    char_if.final_char = 1'b0;
    byte_if.ready      = 1'b0;
  end

  // Character driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    char_beat_t nxt;
    if (!rst_ni) begin
      char_if.valid <= 1'b0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        predict_key_bytes(char_if.key_char, char_if.final_char);
        chars_taken++;
      end
      if (!char_if.valid || char_if.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_chars.pop_front();
          char_if.valid      <= 1'b1;
          char_if.key_char   <= nxt.key_char;
          char_if.final_char <= nxt.final_char;
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // Byte monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : check_bytes
    byte_beat_t got;
    byte_beat_t want;
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        got = '{key_byte: byte_if.key_byte, byte_valid: byte_if.byte_valid,
                run_end: byte_if.run_end, key_end: byte_if.key_end,
                bad_symbol: byte_if.bad_symbol};
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte beat: byte %h valid %b run_end %b key_end %b bad %b",
                   $time, got.key_byte, got.byte_valid, got.run_end, got.key_end,
                   got.bad_symbol);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.key_byte !== want.key_byte || got.byte_valid !== want.byte_valid ||
              got.run_end !== want.run_end || got.key_end !== want.key_end ||
              got.bad_symbol !== want.bad_symbol) begin
            $display("%0t: byte beat mismatch: expected byte %h valid %b run_end %b key_end %b bad %b",
                     $time, want.key_byte, want.byte_valid, want.run_end, want.key_end,
                     want.bad_symbol);
            $display("%0t:                     actual   byte %h valid %b run_end %b key_end %b bad %b",
                     $time, got.key_byte, got.byte_valid, got.run_end, got.key_end,
                     got.bad_symbol);
            error_count++;
          end
        end
      end
      byte_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("base32_key_decoder_top_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    chars_queued  = 0;
    chars_taken   = 0;
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    clear_key_state();
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pads off the cut positions, numerals and lower case in one full group
    queue_text("=1A=8z=7", 1'b0);
    // Several pads, first at position 2 wins; unknown characters flag the byte
    queue_char(8'h00, 1'b0);
    queue_text("b=c==", 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(PadChar, 1'b0);
    // Ignore characters after the cut, then close with a bare end marker
    queue_text("Q", 1'b0);
    queue_char(8'hFF, 1'b1);
    // Partial group dropped at key end
    queue_text("A", 1'b1);
    // Key end on the last byte of a full group
    queue_text("MZXW6YTB", 1'b1);

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 60; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      phase_start = (phase == 0) ? 0 : chars_queued;
      while (chars_queued - phase_start < PhaseItems) queue_random_key();
      while (chars_taken != chars_queued) @(posedge clk_i);
    end

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("base32_key_decoder_top_test passed");
    end else begin
      $display("base32_key_decoder_top_test failed");
    end
    $finish;
  end

endmodule
